### design/cp15_pkg.sv
// Shared types, codes and constants of the system control coprocessor.
// No dependencies; imported by every module of the block.
package cp15_pkg;

  localparam int CP15_REGION_COUNT = 8;

  // Access kind carried in tuser
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // The only coprocessor number served
  localparam logic [3:0] CP15_NUM = 4'd15;

  // Primary register numbers
  localparam logic [3:0] CN_ID       = 4'd0;
  localparam logic [3:0] CN_CTRL     = 4'd1;
  localparam logic [3:0] CN_CACHE    = 4'd2;
  localparam logic [3:0] CN_WBUF     = 4'd3;
  localparam logic [3:0] CN_PERM     = 4'd5;
  localparam logic [3:0] CN_REGION   = 4'd6;
  localparam logic [3:0] CN_CACHE_OP = 4'd7;
  localparam logic [3:0] CN_TCM      = 4'd9;
  localparam logic [3:0] CN_PID      = 4'd13;
  localparam logic [3:0] CN_TEST     = 4'd15;

  // Secondary selectors of the cache command space
  localparam logic [3:0] CM_WFI_A    = 4'd0;
  localparam logic [3:0] CM_WFI_B    = 4'd8;
  localparam logic [3:0] CM_INV_I    = 4'd5;
  localparam logic [3:0] CM_INV_D    = 4'd6;
  localparam logic [3:0] CM_CLEAN_D  = 4'd10;
  localparam logic [2:0] CP_WFI_A    = 3'd4;
  localparam logic [2:0] CP_WFI_B    = 3'd2;
  localparam logic [3:0] CM_TCM      = 4'd1;

  // Fixed words and masks
  localparam logic [31:0] ID_MAIN      = 32'h4105_9461;
  localparam logic [31:0] ID_CACHE     = 32'h0F0D_2112;
  localparam logic [31:0] ID_TCM       = 32'h0014_0180;
  localparam logic [31:0] CTRL_WMASK   = 32'h000F_F085;
  localparam logic [31:0] CTRL_RESET   = 32'h0000_2078;
  localparam logic [31:0] HIGH_VECTORS = 32'hFFFF_0000;
  localparam logic [31:0] TCM_UNIT     = 32'h0000_0200;
  localparam logic [31:0] DTCM_MIN     = 32'h0000_1000;
  localparam logic [31:0] DTCM_AMASK   = 32'hFFFF_F000;
  localparam logic [31:0] DTCM_WMASK   = 32'hFFFF_F03E;
  localparam logic [5:0]  ITCM_WMASK   = 6'h3E;

  localparam int CTRL_DTCM_EN = 16;
  localparam int CTRL_ITCM_EN = 18;
  localparam int CTRL_HIVEC   = 13;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BADCP     = 2'd1,
    STAT_UNHANDLED = 2'd2
  } cp15_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPDATE,
    ST_FINISH
  } cp15_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the incoming item
    logic exec;       // decode, write registers, form read data and status
    logic recompute;  // refresh the derived TCM windows
    logic load_out;   // move the result into the output register
  } cp15_cmd_t;

  // 4-bit permission fields -> 2-bit fields
  function automatic logic [31:0] pack_perm(input logic [31:0] w);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v[2*i +: 2] = w[4*i +: 2];
    end
    return v;
  endfunction

  // 2-bit permission fields -> 4-bit fields
  function automatic logic [31:0] expand_perm(input logic [31:0] w);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      v[4*i +: 2] = w[2*i +: 2];
    end
    return v;
  endfunction

endpackage

### design/cp15_ctrl.sv
// Sequencer of the system control coprocessor: one item at a time.
// Depends on cp15_pkg for the state type and the command struct.
module cp15_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output cp15_pkg::cp15_cmd_t cmd
);
  import cp15_pkg::*;

  cp15_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.capture   = (state_r == ST_IDLE) && in_tvalid;
    cmd.exec      = (state_r == ST_DECODE);
    cmd.recompute = (state_r == ST_UPDATE);
    cmd.load_out  = (state_r == ST_FINISH) && out_free;
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/cp15_dpath.sv
// Register file, access decode, TCM window arithmetic and output register.
// Depends on cp15_pkg; driven by commands from cp15_ctrl.
module cp15_dpath #(
  parameter int REGION_COUNT = cp15_pkg::CP15_REGION_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cp15_pkg::cp15_cmd_t cmd,
  input  logic                in_kind,
  input  logic [3:0]          in_coproc_num,
  input  logic [2:0]          in_opcode,
  input  logic [3:0]          in_cn,
  input  logic [3:0]          in_cm,
  input  logic [2:0]          in_cp,
  input  logic [31:0]         in_write_data,
  output logic [31:0]         out_read_data,
  output logic [1:0]          out_status,
  output logic                out_halt_request,
  output logic [31:0]         out_dtcm_base,
  output logic [31:0]         out_dtcm_end,
  output logic [31:0]         out_dtcm_mask,
  output logic [31:0]         out_itcm_size,
  output logic [31:0]         out_exception_base
);
  import cp15_pkg::*;

  localparam int RIDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  // Latched item
  logic        kind_r;
  logic [3:0]  num_r, cn_r, cm_r;
  logic [2:0]  opc_r, cp_r;
  logic [31:0] wdata_r;

  // Architectural registers
  logic [31:0] control_r, dcache_r, icache_r, wbuf_r, dperm_r, iperm_r, pid_r;
  logic [31:0] region_r [REGION_COUNT];
  logic [31:0] dtcm_set_r;
  logic [5:0]  itcm_set_r;
  logic [31:0] dtcm_base_r, dtcm_end_r, dtcm_mask_r, itcm_size_r, exc_base_r;
  logic        redo_dtcm_r, redo_itcm_r;

  // Result of the access
  logic [31:0]  rdata_r;
  cp15_status_t stat_r;
  logic         halt_r;

  // Decode
  logic [31:0]  rd;
  cp15_status_t st;
  logic         halt;
  logic         we_ctrl, we_dcache, we_icache, we_wbuf, we_dperm, we_iperm;
  logic         perm_packed, we_region, we_dset, we_iset, we_pid;
  logic         cm0, region_hit;
  logic [RIDX_W-1:0] ridx;
  logic [31:0]  region_rd;

  assign cm0        = (cm_r == 4'd0);
  assign region_hit = ({1'b0, cm_r} < 5'(REGION_COUNT)) && (cp_r <= 3'd1);
  assign ridx       = cm_r[RIDX_W-1:0];
  assign region_rd  = region_hit ? region_r[ridx] : '0;

  always_comb begin
    rd = '0; st = STAT_OK; halt = 1'b0;
    we_ctrl = 1'b0; we_dcache = 1'b0; we_icache = 1'b0; we_wbuf = 1'b0;
    we_dperm = 1'b0; we_iperm = 1'b0; perm_packed = 1'b0; we_region = 1'b0;
    we_dset = 1'b0; we_iset = 1'b0; we_pid = 1'b0;
    priority if (num_r != CP15_NUM) begin
      st = STAT_BADCP;
    end else if (opc_r != 3'd0) begin
      st = STAT_UNHANDLED;
    end else if (kind_r == KIND_READ) begin
      st = STAT_UNHANDLED;
      unique case (cn_r)
        CN_ID: if (cm0 && cp_r <= 3'd2) begin
          st = STAT_OK;
          rd = (cp_r == 3'd0) ? ID_MAIN : ((cp_r == 3'd1) ? ID_CACHE : ID_TCM);
        end
        CN_CTRL: if (cm0 && cp_r == 3'd0) begin
          st = STAT_OK; rd = control_r;
        end
        CN_CACHE: if (cm0 && cp_r <= 3'd1) begin
          st = STAT_OK; rd = cp_r[0] ? icache_r : dcache_r;
        end
        CN_WBUF: if (cm0 && cp_r == 3'd0) begin
          st = STAT_OK; rd = wbuf_r;
        end
        CN_PERM: if (cm0 && cp_r <= 3'd3) begin
          st = STAT_OK;
          unique case (cp_r[1:0])
            2'd0:    rd = pack_perm(dperm_r);
            2'd1:    rd = pack_perm(iperm_r);
            2'd2:    rd = dperm_r;
            default: rd = iperm_r;
          endcase
        end
        CN_REGION: if (region_hit) begin
          st = STAT_OK; rd = region_rd;
        end
        CN_TCM: if (cm_r == CM_TCM && cp_r <= 3'd1) begin
          st = STAT_OK; rd = cp_r[0] ? {26'd0, itcm_set_r} : dtcm_set_r;
        end
        CN_PID:  begin st = STAT_OK; rd = pid_r; end
        CN_TEST: st = STAT_OK;
        default: st = STAT_UNHANDLED;
      endcase
    end else begin
      st = STAT_UNHANDLED;
      unique case (cn_r)
        CN_CTRL: if (cm0 && cp_r == 3'd0) begin
          st = STAT_OK; we_ctrl = 1'b1;
        end
        CN_CACHE: if (cm0 && cp_r <= 3'd1) begin
          st = STAT_OK; we_dcache = !cp_r[0]; we_icache = cp_r[0];
        end
        CN_WBUF: if (cm0 && cp_r == 3'd0) begin
          st = STAT_OK; we_wbuf = 1'b1;
        end
        CN_PERM: if (cm0 && cp_r <= 3'd3) begin
          st = STAT_OK; we_dperm = !cp_r[0]; we_iperm = cp_r[0];
          perm_packed = !cp_r[1];
        end
        CN_REGION: if (region_hit) begin
          st = STAT_OK; we_region = 1'b1;
        end
        CN_CACHE_OP: begin
          if ((cm_r == CM_WFI_A && cp_r == CP_WFI_A) ||
              (cm_r == CM_WFI_B && cp_r == CP_WFI_B)) begin
            st = STAT_OK; halt = 1'b1;
          end else if ((cm_r == CM_INV_I && cp_r <= 3'd2) ||
                       (cm_r == CM_INV_D && cp_r <= 3'd1) ||
                       (cm_r == CM_CLEAN_D && (cp_r == 3'd1 || cp_r == 3'd2))) begin
            st = STAT_OK;
          end
        end
        CN_TCM: if (cm_r == CM_TCM && cp_r <= 3'd1) begin
          st = STAT_OK; we_dset = !cp_r[0]; we_iset = cp_r[0];
        end
        CN_PID:  begin st = STAT_OK; we_pid = 1'b1; end
        CN_TEST: st = STAT_OK;
        default: st = STAT_UNHANDLED;
      endcase
    end
  end

  // TCM window arithmetic from the updated settings
  logic [31:0] dsize, dsize_min, dtcm_mask_nxt, dtcm_base_nxt, dtcm_end_nxt;
  logic [31:0] itcm_size_nxt;

  always_comb begin
    dsize         = TCM_UNIT << dtcm_set_r[5:1];
    dsize_min     = (dsize < DTCM_MIN) ? DTCM_MIN : dsize;
    dtcm_mask_nxt = DTCM_AMASK & ~(dsize_min - 32'd1);
    dtcm_base_nxt = dtcm_set_r & dtcm_mask_nxt;
    dtcm_end_nxt  = dtcm_base_nxt + dsize_min;
    if (!control_r[CTRL_DTCM_EN]) begin
      dtcm_mask_nxt = '0;
      dtcm_base_nxt = '1;
      dtcm_end_nxt  = '1;
    end
    itcm_size_nxt = control_r[CTRL_ITCM_EN] ? (TCM_UNIT << itcm_set_r[5:1]) : '0;
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      num_r   <= in_coproc_num;
      opc_r   <= in_opcode;
      cn_r    <= in_cn;
      cm_r    <= in_cm;
      cp_r    <= in_cp;
      wdata_r <= in_write_data;
    end
  end

  // Access result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r <= rd;
      stat_r  <= st;
      halt_r  <= halt;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= CTRL_RESET;
      dcache_r    <= '0;
      icache_r    <= '0;
      wbuf_r      <= '0;
      dperm_r     <= '0;
      iperm_r     <= '0;
      pid_r       <= '0;
      for (int i = 0; i < REGION_COUNT; i++) region_r[i] <= '0;
      dtcm_set_r  <= '0;
      itcm_set_r  <= '0;
      dtcm_base_r <= '1;
      dtcm_end_r  <= '1;
      dtcm_mask_r <= '0;
      itcm_size_r <= '0;
      exc_base_r  <= '0;
      redo_dtcm_r <= 1'b0;
      redo_itcm_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        redo_dtcm_r <= we_ctrl || we_dset;
        redo_itcm_r <= we_ctrl || we_iset;
        if (we_ctrl) begin
          control_r  <= (control_r & ~CTRL_WMASK) | (wdata_r & CTRL_WMASK);
          exc_base_r <= wdata_r[CTRL_HIVEC] ? HIGH_VECTORS : '0;
        end
        if (we_dcache) dcache_r <= wdata_r;
        if (we_icache) icache_r <= wdata_r;
        if (we_wbuf)   wbuf_r   <= wdata_r;
        if (we_dperm)  dperm_r  <= perm_packed ? expand_perm(wdata_r) : wdata_r;
        if (we_iperm)  iperm_r  <= perm_packed ? expand_perm(wdata_r) : wdata_r;
        if (we_region) region_r[ridx] <= wdata_r;
        if (we_dset)   dtcm_set_r <= wdata_r & DTCM_WMASK;
        if (we_iset)   itcm_set_r <= wdata_r[5:0] & ITCM_WMASK;
        if (we_pid)    pid_r <= wdata_r;
      end
      if (cmd.recompute) begin
        if (redo_dtcm_r) begin
          dtcm_mask_r <= dtcm_mask_nxt;
          dtcm_base_r <= dtcm_base_nxt;
          dtcm_end_r  <= dtcm_end_nxt;
        end
        if (redo_itcm_r) itcm_size_r <= itcm_size_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data      <= rdata_r;
      out_status         <= stat_r;
      out_halt_request   <= halt_r;
      out_dtcm_base      <= dtcm_base_r;
      out_dtcm_end       <= dtcm_end_r;
      out_dtcm_mask      <= dtcm_mask_r;
      out_itcm_size      <= itcm_size_r;
      out_exception_base <= exc_base_r;
    end
  end

endmodule

### design/cp15_system_control_coprocessor.sv
// Top level of the system control coprocessor (CP15).
// Depends on cp15_pkg, cp15_ctrl and cp15_dpath.
//
// Usage:
//  - Slave channel (in_*): one coprocessor access per item. in_tuser is the
//    access kind (0 read, 1 write); in_tdata carries the selectors and data.
//  - Master channel (out_*): one result per item. out_tuser is the status
//    (0 handled, 1 wrong coprocessor, 2 unhandled); out_tdata carries the
//    read data, the halt flag and the current TCM windows and vector base.
//  - An accepted item runs through decode and register write, TCM window
//    update and output load before it appears on out_tvalid.
//  - One item at a time: the sequencer walks capture, decode, update and load
//    for each item and takes no new item before it returns to capture.
//  - The output register decouples the sides: a new item is accepted while
//    the previous result still waits; if the receiver stalls, the next result
//    holds in the sequencer until the output register frees up.
//  - Reset (rst_n low, synchronous) returns the registers to their defined
//    values: control word 0x2078, data TCM disabled (base and end all ones),
//    everything else zero, and drops any pending result.
module cp15_system_control_coprocessor #(
  parameter int REGION_COUNT = cp15_pkg::CP15_REGION_COUNT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // kind
  // coproc_num[3:0], opcode[6:4], cn[10:7], cm[14:11], cp[17:15],
  // write_data[49:18], zero pad[55:50]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  // read_data[31:0], halt_request[32], dtcm_base[64:33], dtcm_end[96:65],
  // dtcm_mask[128:97], itcm_size[160:129], exception_base[192:161],
  // zero pad[199:193]
  output logic [199:0] out_tdata
);
  import cp15_pkg::*;

  cp15_cmd_t cmd;

  cp15_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  logic [31:0] read_data, dtcm_base, dtcm_end, dtcm_mask, itcm_size, exc_base;
  logic        halt_request;

  cp15_dpath #(
    .REGION_COUNT (REGION_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_kind            (in_tuser),
    .in_coproc_num      (in_tdata[3:0]),
    .in_opcode          (in_tdata[6:4]),
    .in_cn              (in_tdata[10:7]),
    .in_cm              (in_tdata[14:11]),
    .in_cp              (in_tdata[17:15]),
    .in_write_data      (in_tdata[49:18]),
    .out_read_data      (read_data),
    .out_status         (out_tuser),
    .out_halt_request   (halt_request),
    .out_dtcm_base      (dtcm_base),
    .out_dtcm_end       (dtcm_end),
    .out_dtcm_mask      (dtcm_mask),
    .out_itcm_size      (itcm_size),
    .out_exception_base (exc_base)
  );

  // Pack the result, highest field first
  assign out_tdata = {7'd0, exc_base, itcm_size, dtcm_mask, dtcm_end, dtcm_base,
                      halt_request, read_data};

endmodule

### tb/cp15_access_checker.sv
// Selector constants and the result scoreboard of the system control coprocessor test.
// Depends on cp15_pkg; the package here is shared with the test top.
package cp15_access_pkg;
  import cp15_pkg::*;

  localparam logic [2:0] OPC_SERVED  = 3'd0;
  localparam logic [3:0] CM_BASE     = 4'd0;
  localparam logic [3:0] CM_LOCKDOWN = 4'd0;
  localparam logic [2:0] CP_BASE     = 3'd0;

  localparam logic [2:0] CP_ID_MAIN  = 3'd0;
  localparam logic [2:0] CP_ID_CACHE = 3'd1;
  localparam logic [2:0] CP_ID_TCM   = 3'd2;

  localparam logic [2:0] CP_DATA     = 3'd0;
  localparam logic [2:0] CP_CODE     = 3'd1;
  localparam logic [2:0] CP_DATA_EXT = 3'd2;
  localparam logic [2:0] CP_CODE_EXT = 3'd3;

  localparam logic [2:0] CP_DTCM     = 3'd0;
  localparam logic [2:0] CP_ITCM     = 3'd1;

  localparam logic [2:0] CP_REGION_MAX = 3'd1;
  localparam logic [2:0] CP_INV_I_MAX  = 3'd2;
  localparam logic [2:0] CP_INV_D_MAX  = 3'd1;
  localparam logic [2:0] CP_CLEAN_LO   = 3'd1;
  localparam logic [2:0] CP_CLEAN_HI   = 3'd2;

  localparam logic [3:0] LAST_REGION         = 4'(CP15_REGION_COUNT - 1);
  localparam logic [3:0] FIRST_ABSENT_REGION = 4'(CP15_REGION_COUNT);

  // Lay out one access as the input bus carries it
  function automatic logic [55:0] pack_access(input logic [3:0] num, input logic [2:0] opc,
                                              input logic [3:0] cn, input logic [3:0] cm,
                                              input logic [2:0] cp, input logic [31:0] wd);
    return {6'b0, wd, cp, cm, cn, opc, num};
  endfunction
endpackage

module cp15_access_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic         in_tuser,
  input  logic [55:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [1:0]   out_tuser,
  input  logic [199:0] out_tdata,
  output int           mismatch_count,
  output int           waiting_count,
  output int           checked_count,
  output int           halt_count
);
  import cp15_pkg::*;
  import cp15_access_pkg::*;

  localparam int REGION_IDX_W = $clog2(CP15_REGION_COUNT);

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic        halt_request;
    logic [31:0] dtcm_base;
    logic [31:0] dtcm_end;
    logic [31:0] dtcm_mask;
    logic [31:0] itcm_size;
    logic [31:0] exception_base;
  } access_result_t;

  // Shadow copy of the register file and the derived windows
  logic [31:0] ctrl_q, dcache_q, icache_q, wbuf_q, dperm_q, iperm_q, dtcm_cfg_q, pid_q;
  logic [5:0]  itcm_cfg_q;
  logic [31:0] region_q [CP15_REGION_COUNT];
  logic [31:0] dtcm_base_q, dtcm_end_q, dtcm_mask_q, itcm_size_q, vec_base_q;

  access_result_t expected_results [$];

  function automatic logic [31:0] tcm_window(input logic [31:0] setting);
    return TCM_UNIT << setting[5:1];
  endfunction

  // Keep the low two bits of each nibble, side by side
  function automatic logic [31:0] perm_to_short(input logic [31:0] w);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 16; b++) v[b] = w[4 * (b / 2) + b % 2];
    return v;
  endfunction

  function automatic logic [31:0] perm_to_long(input logic [31:0] w);
    logic [31:0] v;
    v = '0;
    for (int b = 0; b < 16; b++) v[4 * (b / 2) + b % 2] = w[b];
    return v;
  endfunction

  task automatic refresh_dtcm();
    logic [31:0] span;
    if (!ctrl_q[CTRL_DTCM_EN]) begin
      dtcm_mask_q = '0;
      dtcm_base_q = '1;
      dtcm_end_q  = '1;
    end else begin
      span = tcm_window(dtcm_cfg_q);
      if (span < DTCM_MIN) span = DTCM_MIN;
      dtcm_mask_q = DTCM_AMASK & ~(span - 32'd1);
      dtcm_base_q = dtcm_cfg_q & dtcm_mask_q;
      dtcm_end_q  = dtcm_base_q + span;
    end
  endtask

  task automatic refresh_itcm();
    itcm_size_q = ctrl_q[CTRL_ITCM_EN] ? tcm_window({26'b0, itcm_cfg_q}) : '0;
  endtask

  task automatic compare_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("mismatch on %s of result %0d: expected %h, got %h",
                 field_name, checked_count, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    access_result_t want;
    logic [3:0]  cn, cm;
    logic [2:0]  cp;
    logic [31:0] wd;
    if (!rst_n) begin
      expected_results.delete();
      ctrl_q = CTRL_RESET;
      dcache_q = '0;
      icache_q = '0;
      wbuf_q = '0;
      dperm_q = '0;
      iperm_q = '0;
      for (int i = 0; i < CP15_REGION_COUNT; i++) region_q[i] = '0;
      dtcm_cfg_q = '0;
      itcm_cfg_q = '0;
      pid_q = '0;
      dtcm_base_q = '1;
      dtcm_end_q = '1;
      dtcm_mask_q = '0;
      itcm_size_q = '0;
      vec_base_q = '0;
      mismatch_count = 0;
      checked_count = 0;
      halt_count = 0;
      waiting_count = 0;
    end else begin
      // A result leaving now belongs to an earlier access: compare before predicting
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("result %0d arrived with no access outstanding", checked_count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", {30'b0, want.status}, {30'b0, out_tuser});
          compare_field("read_data", want.read_data, out_tdata[31:0]);
          compare_field("halt_request", {31'b0, want.halt_request}, {31'b0, out_tdata[32]});
          compare_field("dtcm_base", want.dtcm_base, out_tdata[64:33]);
          compare_field("dtcm_end", want.dtcm_end, out_tdata[96:65]);
          compare_field("dtcm_mask", want.dtcm_mask, out_tdata[128:97]);
          compare_field("itcm_size", want.itcm_size, out_tdata[160:129]);
          compare_field("exception_base", want.exception_base, out_tdata[192:161]);
        end
        if (out_tdata[32] === 1'b1) halt_count++;
        checked_count++;
      end

      if (in_tvalid && in_tready) begin
        cn = in_tdata[10:7];
        cm = in_tdata[14:11];
        cp = in_tdata[17:15];
        wd = in_tdata[49:18];
        want = '0;
        if (in_tdata[3:0] != CP15_NUM) begin
          want.status = STAT_BADCP;
        end else if (in_tdata[6:4] != OPC_SERVED) begin
          want.status = STAT_UNHANDLED;
        end else if (in_tuser == KIND_READ) begin
          case (cn)
            CN_ID: begin
              if (cm != CM_BASE) want.status = STAT_UNHANDLED;
              else if (cp == CP_ID_MAIN) want.read_data = ID_MAIN;
              else if (cp == CP_ID_CACHE) want.read_data = ID_CACHE;
              else if (cp == CP_ID_TCM) want.read_data = ID_TCM;
              else want.status = STAT_UNHANDLED;
            end
            CN_CTRL: begin
              if (cm == CM_BASE && cp == CP_BASE) want.read_data = ctrl_q;
              else want.status = STAT_UNHANDLED;
            end
            CN_CACHE: begin
              if (cm != CM_BASE) want.status = STAT_UNHANDLED;
              else if (cp == CP_DATA) want.read_data = dcache_q;
              else if (cp == CP_CODE) want.read_data = icache_q;
              else want.status = STAT_UNHANDLED;
            end
            CN_WBUF: begin
              if (cm == CM_BASE && cp == CP_BASE) want.read_data = wbuf_q;
              else want.status = STAT_UNHANDLED;
            end
            CN_PERM: begin
              if (cm != CM_BASE) want.status = STAT_UNHANDLED;
              else if (cp == CP_DATA) want.read_data = perm_to_short(dperm_q);
              else if (cp == CP_CODE) want.read_data = perm_to_short(iperm_q);
              else if (cp == CP_DATA_EXT) want.read_data = dperm_q;
              else if (cp == CP_CODE_EXT) want.read_data = iperm_q;
              else want.status = STAT_UNHANDLED;
            end
            CN_REGION: begin
              if (cm < CP15_REGION_COUNT && cp <= CP_REGION_MAX)
                want.read_data = region_q[cm[REGION_IDX_W-1:0]];
              else want.status = STAT_UNHANDLED;
            end
            CN_TCM: begin
              if (cm != CM_TCM) want.status = STAT_UNHANDLED;
              else if (cp == CP_DTCM) want.read_data = dtcm_cfg_q;
              else if (cp == CP_ITCM) want.read_data = {26'b0, itcm_cfg_q};
              else want.status = STAT_UNHANDLED;
            end
            CN_PID: want.read_data = pid_q;
            CN_TEST: want.read_data = '0;
            default: want.status = STAT_UNHANDLED;
          endcase
        end else begin
          case (cn)
            CN_CTRL: begin
              if (cm == CM_BASE && cp == CP_BASE) begin
                ctrl_q = (ctrl_q & ~CTRL_WMASK) | (wd & CTRL_WMASK);
                refresh_dtcm();
                refresh_itcm();
                // vector base follows the written bit, masked or not
                vec_base_q = wd[CTRL_HIVEC] ? HIGH_VECTORS : '0;
              end else begin
                want.status = STAT_UNHANDLED;
              end
            end
            CN_CACHE: begin
              if (cm != CM_BASE) want.status = STAT_UNHANDLED;
              else if (cp == CP_DATA) dcache_q = wd;
              else if (cp == CP_CODE) icache_q = wd;
              else want.status = STAT_UNHANDLED;
            end
            CN_WBUF: begin
              if (cm == CM_BASE && cp == CP_BASE) wbuf_q = wd;
              else want.status = STAT_UNHANDLED;
            end
            CN_PERM: begin
              if (cm != CM_BASE) want.status = STAT_UNHANDLED;
              else if (cp == CP_DATA) dperm_q = perm_to_long(wd);
              else if (cp == CP_CODE) iperm_q = perm_to_long(wd);
              else if (cp == CP_DATA_EXT) dperm_q = wd;
              else if (cp == CP_CODE_EXT) iperm_q = wd;
              else want.status = STAT_UNHANDLED;
            end
            CN_REGION: begin
              if (cm < CP15_REGION_COUNT && cp <= CP_REGION_MAX)
                region_q[cm[REGION_IDX_W-1:0]] = wd;
              else want.status = STAT_UNHANDLED;
            end
            CN_CACHE_OP: begin
              if ((cm == CM_WFI_A && cp == CP_WFI_A) || (cm == CM_WFI_B && cp == CP_WFI_B))
                want.halt_request = 1'b1;
              else if (!((cm == CM_INV_I && cp <= CP_INV_I_MAX) ||
                         (cm == CM_INV_D && cp <= CP_INV_D_MAX) ||
                         (cm == CM_CLEAN_D && cp >= CP_CLEAN_LO && cp <= CP_CLEAN_HI)))
                want.status = STAT_UNHANDLED;
            end
            CN_TCM: begin
              if (cm == CM_TCM && cp == CP_DTCM) begin
                dtcm_cfg_q = wd & DTCM_WMASK;
                refresh_dtcm();
              end else if (cm == CM_TCM && cp == CP_ITCM) begin
                itcm_cfg_q = wd[5:0] & ITCM_WMASK;
                refresh_itcm();
              end else begin
                want.status = STAT_UNHANDLED;
              end
            end
            CN_PID: pid_q = wd;
            CN_TEST: ;
            default: want.status = STAT_UNHANDLED;
          endcase
        end
        want.dtcm_base      = dtcm_base_q;
        want.dtcm_end       = dtcm_end_q;
        want.dtcm_mask      = dtcm_mask_q;
        want.itcm_size      = itcm_size_q;
        want.exception_base = vec_base_q;
        expected_results.push_back(want);
      end
      waiting_count = expected_results.size();
    end
  end

endmodule

### tb/cp15_system_control_coprocessor_test.sv
// Test top of the system control coprocessor: clock, reset, access stimulus and verdict.
// Depends on cp15_pkg, the block itself and cp15_access_checker (with cp15_access_pkg).
module cp15_system_control_coprocessor_test;
  import cp15_pkg::*;
  import cp15_access_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 3;
  localparam int RANDOM_ACCESSES = 1800;
  localparam int HOLDOFF_CYCLES  = 150;
  // Set well above the length of the slowest correct run
  localparam int LIMIT_CYCLES    = 200000;
  // After the last expected result, keep watching for any stray result
  localparam int DRAIN_CYCLES    = 12;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic         in_tuser = 1'b0;   // kind
  // coproc_num[3:0], opcode[6:4], cn[10:7], cm[14:11], cp[17:15], write_data[49:18]
  logic [55:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;         // status
  // read_data[31:0], halt_request[32], dtcm_base[64:33], dtcm_end[96:65],
  // dtcm_mask[128:97], itcm_size[160:129], exception_base[192:161]
  logic [199:0] out_tdata;

  int mismatch_count, waiting_count, checked_count, halt_count;
  int sent_count = 0;
  int directed_count = 0;
  int holdoff_count = 0;

  always #HALF_PERIOD clk = ~clk;

  cp15_system_control_coprocessor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  cp15_access_checker access_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tuser      (out_tuser),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .waiting_count  (waiting_count),
    .checked_count  (checked_count),
    .halt_count     (halt_count)
  );

  // Offer one item and hold it until the block takes it. Draw a random gap of
  // idle cycles first, except in every fourth stretch of 150 items, which runs
  // back to back. With no gap, valid simply stays high for the next item.
  task automatic send_access(input logic kind, input logic [55:0] data);
    int gap;
    gap = ((sent_count / 150) % 4 == 1) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Access to coprocessor 15 with the served opcode
  task automatic issue_access(input logic kind, input logic [3:0] cn, input logic [3:0] cm,
                              input logic [2:0] cp, input logic [31:0] wd);
    send_access(kind, pack_access(CP15_NUM, OPC_SERVED, cn, cm, cp, wd));
  endtask

  // Result side: draw a random stall before each item, run without stalls in
  // every fourth stretch of 150 items, and twice hold off for a long stretch
  // so that the output register and the sequencer fill and the input backs up.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken == 40 || taken == 1000) begin
        out_tready <= 1'b0;
        holdoff_count++;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else begin
        stall = ((taken / 150) % 4 == 2) ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    logic        kind;
    logic [3:0]  num, cn, cm;
    logic [2:0]  opc, cp;
    logic [31:0] wd;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: ID words, read-only write, both TCM windows at their
    // extremes, permission forms, last and first missing region, halts and
    // cache commands, lockdown, a stray opcode and a wrong coprocessor.
    issue_access(KIND_READ,  CN_ID, CM_BASE, CP_ID_MAIN, '0);
    issue_access(KIND_READ,  CN_ID, CM_BASE, CP_ID_CACHE, '0);
    issue_access(KIND_READ,  CN_ID, CM_BASE, CP_ID_TCM, '0);
    issue_access(KIND_WRITE, CN_ID, CM_BASE, CP_ID_MAIN, '1);
    // every writable control bit set: both TCMs on, high vectors
    issue_access(KIND_WRITE, CN_CTRL, CM_BASE, CP_BASE, '1);
    // largest size field: the size wraps to zero and the data window clamps
    issue_access(KIND_WRITE, CN_TCM, CM_TCM, CP_DTCM, '1);
    issue_access(KIND_WRITE, CN_TCM, CM_TCM, CP_ITCM, '1);
    issue_access(KIND_WRITE, CN_TCM, CM_TCM, CP_DTCM, '0);
    issue_access(KIND_READ,  CN_TCM, CM_TCM, CP_DTCM, '0);
    issue_access(KIND_WRITE, CN_TCM, CM_TCM, CP_ITCM, 32'h0000_0014);
    issue_access(KIND_READ,  CN_CTRL, CM_BASE, CP_BASE, '0);
    issue_access(KIND_WRITE, CN_PERM, CM_BASE, CP_DATA, '1);
    issue_access(KIND_READ,  CN_PERM, CM_BASE, CP_DATA_EXT, '0);
    issue_access(KIND_WRITE, CN_PERM, CM_BASE, CP_CODE_EXT, 32'hA5A5_A5A5);
    issue_access(KIND_READ,  CN_PERM, CM_BASE, CP_CODE, '0);
    issue_access(KIND_WRITE, CN_REGION, LAST_REGION, CP_REGION_MAX, 32'h1234_5678);
    issue_access(KIND_READ,  CN_REGION, LAST_REGION, CP_BASE, '0);
    issue_access(KIND_READ,  CN_REGION, FIRST_ABSENT_REGION, CP_BASE, '0);
    issue_access(KIND_WRITE, CN_CACHE_OP, CM_WFI_A, CP_WFI_A, '0);
    issue_access(KIND_WRITE, CN_CACHE_OP, CM_WFI_B, CP_WFI_B, '1);
    issue_access(KIND_WRITE, CN_CACHE_OP, CM_CLEAN_D, CP_CLEAN_HI, '0);
    issue_access(KIND_READ,  CN_CACHE_OP, CM_WFI_A, CP_WFI_A, '0);
    issue_access(KIND_READ,  CN_TCM, CM_LOCKDOWN, CP_DTCM, '0);
    send_access(KIND_READ, pack_access(CP15_NUM, '1, CN_ID, CM_BASE, CP_ID_MAIN, '0));
    // wrong coprocessor: the control word must not change
    send_access(KIND_WRITE, pack_access('0, OPC_SERVED, CN_CTRL, CM_BASE, CP_BASE, '0));
    directed_count = sent_count;

    // Random part: mostly well-formed accesses to decoded registers, with
    // neighbouring selectors, stray opcodes and raw noise mixed in.
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      kind = 1'($urandom_range(0, 1));
      wd   = $urandom;
      num  = CP15_NUM;
      opc  = OPC_SERVED;
      cm   = CM_BASE;
      cp   = CP_BASE;
      if ($urandom_range(0, 99) < 8) begin
        {num, opc, cn, cm, cp} = 18'($urandom);
      end else begin
        case ($urandom_range(0, 11))
          0: begin
            cn = CN_ID;
            cp = 3'($urandom_range(0, 3));
          end
          1, 2: cn = CN_CTRL;
          3: begin
            cn = CN_CACHE;
            cp = 3'($urandom_range(0, 2));
          end
          4: cn = CN_WBUF;
          5: begin
            cn = CN_PERM;
            cp = 3'($urandom_range(0, 4));
          end
          6: begin
            cn = CN_REGION;
            cm = 4'($urandom_range(0, CP15_REGION_COUNT));
            cp = 3'($urandom_range(0, 2));
          end
          7: begin
            cn = CN_CACHE_OP;
            case ($urandom_range(0, 5))
              0: cm = CM_WFI_A;
              1: cm = CM_WFI_B;
              2: cm = CM_INV_I;
              3: cm = CM_INV_D;
              4: cm = CM_CLEAN_D;
              default: cm = 4'($urandom);
            endcase
            cp = 3'($urandom_range(0, 4));
          end
          8, 9: begin
            cn = CN_TCM;
            cm = ($urandom_range(0, 3) == 0) ? CM_LOCKDOWN : CM_TCM;
            cp = 3'($urandom_range(0, 2));
            // favour small size fields so that real windows appear
            if ($urandom_range(0, 1) == 1) wd[5:1] = 5'($urandom_range(0, 12));
          end
          10: begin
            cn = ($urandom_range(0, 1) == 1) ? CN_PID : CN_TEST;
            cm = 4'($urandom);
            cp = 3'($urandom);
          end
          default: begin
            cn = 4'($urandom);
            cp = 3'($urandom_range(0, 3));
          end
        endcase
        if ($urandom_range(0, 19) == 0) opc = 3'($urandom);
      end
      send_access(kind, pack_access(num, opc, cn, cm, cp, wd));
    end
    in_tvalid <= 1'b0;

    // Drain: let every outstanding result arrive, then watch for strays
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d accesses (%0d directed, rest random) under %0d long output stalls;",
             sent_count, directed_count, holdoff_count);
    $display("checked %0d results, %0d of them halt requests, %0d mismatches.",
             checked_count, halt_count, mismatch_count);
    if (mismatch_count == 0 && waiting_count == 0) begin
      $display("[cp15_system_control_coprocessor] OK");
    end else begin
      $display("[cp15_system_control_coprocessor] ERROR");
    end
    $finish;
  end

  // Hard stop if the handshakes never complete
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("[cp15_system_control_coprocessor] ERROR");
    $finish;
  end

endmodule
